// File: rtl/core/lcpr_pkg.sv
// ----------------------------------------------------------------------------
// lcpr_pkg
// Shared constants, types and the correction table of the LED current
// regulator.
// ----------------------------------------------------------------------------
package lcpr_pkg;

	localparam int WinDepth    = 16;
	localparam int WinBits     = $clog2(WinDepth);
	localparam int SampleBits  = 12;
	localparam int SumBits     = SampleBits + WinBits;
	localparam logic [15:0] PulseReset = 16'd1300;
	localparam int CorrLast    = 29;

	// register indexes of the configuration port
	localparam logic [1:0] REG_MV_SCALE = 2'd0;
	localparam logic [1:0] REG_PROP     = 2'd1;
	localparam logic [1:0] REG_INTEG    = 2'd2;

	// bit-serial multiplier: 64-bit accumulator, multiplier up to 48 bits
	localparam int MulBits  = 48;
	localparam int MulCntW  = $clog2(MulBits + 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MV_MUL,
		ST_MV_DONE,
		ST_DIV,
		ST_CUR_MUL,
		ST_CUR_DONE,
		ST_INTEG_MUL,
		ST_INNER,
		ST_PROP_MUL,
		ST_FINISH,
		ST_OUT
	} lcpr_state_t;

	// start request and result of the shared serial multiplier
	typedef struct packed {
		logic        start;
		logic        sgn;       // multiplicand is signed
		logic [63:0] mcand;
		logic [47:0] mplier;    // unsigned
		logic [5:0]  nbits;     // multiplier bits to walk
	} lcpr_mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] prod;
	} lcpr_mul_rsp_t;

	function automatic logic [15:0] corr_rom(input logic [4:0] idx);
		logic [15:0] v;
		case (idx)
			5'd0:  v = 16'd25172; 5'd1:  v = 16'd25172; 5'd2:  v = 16'd25253;
			5'd3:  v = 16'd25289; 5'd4:  v = 16'd25341; 5'd5:  v = 16'd25852;
			5'd6:  v = 16'd26327; 5'd7:  v = 16'd26755; 5'd8:  v = 16'd27235;
			5'd9:  v = 16'd27622; 5'd10: v = 16'd28438; 5'd11: v = 16'd28733;
			5'd12: v = 16'd29481; 5'd13: v = 16'd30222; 5'd14: v = 16'd30928;
			5'd15: v = 16'd31605; 5'd16: v = 16'd32272; 5'd17: v = 16'd32915;
			5'd18: v = 16'd33551; 5'd19: v = 16'd34170; 5'd20: v = 16'd35008;
			5'd21: v = 16'd35829; 5'd22: v = 16'd36394; 5'd23: v = 16'd37174;
			5'd24: v = 16'd37922; 5'd25: v = 16'd38334; 5'd26: v = 16'd38352;
			5'd27: v = 16'd39820; 5'd28: v = 16'd39892; 5'd29: v = 16'd40351;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/core/lcpr_serial_mul.sv
// ----------------------------------------------------------------------------
// lcpr_serial_mul
// Shift-and-add multiplier, one multiplier bit per cycle. The multiplicand
// may be signed (two's complement, 64 bits); the multiplier is unsigned.
// ----------------------------------------------------------------------------
module lcpr_serial_mul import lcpr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  lcpr_mul_req_t req,
	output lcpr_mul_rsp_t rsp
);

	logic [63:0] acc_q;
	logic [63:0] mcand_q;
	logic [47:0] mplier_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	// walk multiplier bits from the lsb, multiplicand shifts left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q    <= '0;
			mcand_q  <= req.mcand;
			mplier_q <= req.mplier;
		end else if (busy_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q  <= {mcand_q[62:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[47:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

// File: rtl/core/lcpr_serial_div.sv
// ----------------------------------------------------------------------------
// lcpr_serial_div
// Restoring divider by 25 for a 16-bit value, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lcpr_serial_div import lcpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	output logic        done,
	output logic [15:0] quotient
);

	logic [15:0] quo_q;
	logic [4:0]  rem_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [5:0]  trial;

	assign trial = {rem_q, quo_q[15]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	// quotient bits shift in as dividend bits shift out
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= 6'd25) begin
				rem_q <= 5'(trial - 6'd25);
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= trial[4:0];
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/core/led_current_pi_regulator_unit.sv
// ----------------------------------------------------------------------------
// led_current_pi_regulator_unit
// LED current regulator: moving-average sense filter, corrected current
// estimate and a PI loop that updates the duty level every window.
// ----------------------------------------------------------------------------
// Use: one request on s_axis carries an ADC reading and a target current;
// one result leaves on m_axis with duty level, measured current and a flag
// telling whether the PI update ran. Registers are to be written through
// cfg_* while the block is idle; unknown indexes are ignored. The block
// does not enforce the idle rule. One request is in flight at a time.
// From accept to result valid a request passes the mV multiply, the
// divide by 25 and the correction multiply, and with an update also the
// integral and proportional multiplies, on the bit-serial multiplier
// and divider. s_axis_tready is high only when idle. A stalled m_axis
// holds the result and blocks the next request.
// Reset restores default registers, an empty window, tick count one,
// correction pointer zero, duty 1300 and a zero integrator.
// ----------------------------------------------------------------------------
module led_current_pi_regulator_unit import lcpr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // adc_sample[11:0], target_current_ma[26:12]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // duty_level[15:0], measured_current_ma[31:16]
	output logic        m_axis_tuser,   // loop_updated
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data
);

	lcpr_state_t state_q, state_d;

	logic [16:0] mv_scale_q;
	logic [15:0] prop_gain_q, integ_gain_q;
	logic [SampleBits-1:0] win_q [WinDepth];
	logic [SumBits-1:0] sum_q;
	logic [7:0]  tick_q;
	logic [4:0]  cidx_q;
	logic [15:0] duty_q;
	logic signed [31:0] integ_q;
	logic [14:0] target_q;
	logic        upd_q;
	logic [15:0] cur_q;
	logic signed [16:0] err_q;
	logic signed [63:0] inner_q;

	lcpr_mul_req_t mreq;
	lcpr_mul_rsp_t mrsp;
	logic          div_start, div_done;
	logic [15:0]   div_quo;
	logic [15:0]   mv_sat;

	lcpr_serial_mul u_mul (.clk, .arst_n, .req(mreq), .rsp(mrsp));
	lcpr_serial_div u_div (.clk, .arst_n, .start(div_start), .dividend(mv_sat),
		.done(div_done), .quotient(div_quo));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_scale_q   <= 17'd52816;
			prop_gain_q  <= 16'd768;
			integ_gain_q <= 16'd1311;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MV_SCALE: mv_scale_q   <= cfg_data;
				REG_PROP:     prop_gain_q  <= cfg_data[15:0];
				REG_INTEG:    integ_gain_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic in_fire;
	assign in_fire = s_axis_tvalid && s_axis_tready;

	logic [15:0] brk;
	assign brk = 16'd1300 + 16'(cidx_q) * 16'd100;

	// combinational helpers
	logic [SumBits-1:0] sum_new;
	logic [15:0] avg;
	logic [63:0] cur_full;
	logic signed [17:0] err_raw;
	logic signed [16:0] err_sat;
	logic signed [32:0] acc_new;
	logic signed [31:0] integ_new;
	logic signed [63:0] inner_sum, inner_cl, total;
	assign sum_new  = sum_q + SumBits'(s_axis_tdata[SampleBits-1:0])
		- SumBits'(win_q[WinDepth-1]);
	assign avg      = 16'(sum_q >> WinBits);
	assign mv_sat   = (mrsp.prod[63:32] != '0) ? 16'hFFFF : mrsp.prod[31:16];
	assign cur_full = mrsp.prod >> 14;
	assign err_raw  = $signed({3'b0, target_q}) - $signed({2'b0, cur_q});
	assign err_sat  = (err_raw < -18'sd32768) ? -17'sd32768 :
		(err_raw > 18'sd32767) ? 17'sd32767 : err_raw[16:0];
	assign acc_new  = 33'(integ_q) + 33'(err_sat);
	assign integ_new = (acc_new > 33'sd2147483647) ? 32'sh7FFFFFFF :
		(acc_new < -33'sd2147483648) ? 32'sh80000000 : acc_new[31:0];
	assign inner_sum = ($signed(64'(err_q)) <<< 16) + $signed(mrsp.prod);
	assign inner_cl  = (inner_sum > (64'sd1 <<< 46)) ? (64'sd1 <<< 46) :
		(inner_sum < -(64'sd1 <<< 46)) ? -(64'sd1 <<< 46) : inner_sum;
	assign total = $signed({24'b0, duty_q, 24'b0}) + $signed(mrsp.prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// sequencer
	always_comb begin
		state_d   = state_q;
		mreq      = '0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: if (in_fire) state_d = ST_MV_MUL;
			ST_MV_MUL: begin
				mreq = '{1'b1, 1'b0, 64'(avg), 48'(mv_scale_q), 6'd17};
				state_d = ST_MV_DONE;
			end
			ST_MV_DONE: if (mrsp.done) state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) state_d = ST_CUR_MUL;
			end
			ST_CUR_MUL: begin
				mreq = '{1'b1, 1'b0, 64'(div_quo) * 64'd5, 48'(corr_rom(cidx_q)), 6'd16};
				state_d = ST_CUR_DONE;
			end
			ST_CUR_DONE: if (mrsp.done) state_d = upd_q ? ST_INTEG_MUL : ST_OUT;
			ST_INTEG_MUL: begin
				// integral gain multiplies the freshly updated integrator
				mreq = '{1'b1, 1'b1, 64'(integ_new), 48'(integ_gain_q), 6'd16};
				state_d = ST_INNER;
			end
			ST_INNER: if (mrsp.done) state_d = ST_PROP_MUL;
			ST_PROP_MUL: begin
				mreq = '{1'b1, 1'b1, inner_q, 48'(prop_gain_q), 6'd16};
				state_d = ST_FINISH;
			end
			ST_FINISH: if (mrsp.done) state_d = ST_OUT;
			ST_OUT: if (m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_MV_DONE && mrsp.done) div_start = 1'b1;
	end

	// datapath state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WinDepth; i++) win_q[i] <= '0;
			sum_q   <= '0;
			tick_q  <= 8'd1;
			cidx_q  <= '0;
			duty_q  <= PulseReset;
			integ_q <= '0;
			upd_q   <= 1'b0;
		end else begin
			if (in_fire) begin
				for (int i = WinDepth - 1; i > 0; i--) win_q[i] <= win_q[i-1];
				win_q[0] <= s_axis_tdata[SampleBits-1:0];
				sum_q    <= sum_new;
				tick_q   <= tick_q + 8'd1;
				upd_q    <= (tick_q[WinBits-1:0] == '0);
				// pointer steps toward previous duty
				if (duty_q > brk && cidx_q < 5'(CorrLast)) cidx_q <= cidx_q + 5'd1;
				else if (duty_q < brk && cidx_q != 5'd0) cidx_q <= cidx_q - 5'd1;
			end
			if (state_q == ST_INTEG_MUL) integ_q <= integ_new;
			if (state_q == ST_FINISH && mrsp.done) begin
				if (total < 0) duty_q <= '0;
				else if (total[63:40] != '0) duty_q <= 16'hFFFF;
				else duty_q <= total[39:24];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) target_q <= s_axis_tdata[26:12];
		if (state_q == ST_CUR_DONE && mrsp.done)
			cur_q <= (cur_full[63:16] != '0) ? 16'hFFFF : cur_full[15:0];
		if (state_q == ST_INTEG_MUL) err_q <= err_sat;
		if (state_q == ST_INNER && mrsp.done) inner_q <= inner_cl;
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {cur_q, duty_q};
	assign m_axis_tuser  = upd_q;

`ifndef SYNTH
	// input is taken only while idle
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
	// a stalled result keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed under stall");
	// pointer stays inside the table
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		cidx_q <= 5'(CorrLast)) else $error("correction pointer out of range");
`endif

endmodule

// File: tb/led_current_pi_regulator_unit_test.sv
// ----------------------------------------------------------------------------
// led_current_pi_regulator_unit_test
// Streams ADC readings and target currents into the LED current regulator,
// predicts duty level, measured current and the update flag for each request
// and compares every result in order. Runs through several register settings
// and idle/stall phases, including a long output hold-off.
// ----------------------------------------------------------------------------
module led_current_pi_regulator_unit_test import lcpr_pkg::*; ;

	typedef struct packed {
		logic [14:0] target;
		logic [11:0] sample;
	} sense_req_t;

	typedef struct {
		logic [15:0] duty;
		logic [15:0] current;
		logic        updated;
	} loop_result_t;

	localparam int CorrRom [30] = '{
		25172, 25172, 25253, 25289, 25341, 25852, 26327, 26755, 27235, 27622,
		28438, 28733, 29481, 30222, 30928, 31605, 32272, 32915, 33551, 34170,
		35008, 35829, 36394, 37174, 37922, 38334, 38352, 39820, 39892, 40351};
	localparam int WatchLimit = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [16:0] cfg_data = '0;

	led_current_pi_regulator_unit dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [11:0] win [WinDepth];
	logic [15:0] win_sum;
	logic [7:0]  tick;
	logic [4:0]  corr_ptr;
	logic [15:0] duty;
	longint      integ;
	logic [16:0] mv_scale;
	logic [15:0] kp, ki;

	sense_req_t   pending_reqs [$];
	loop_result_t expected_results [$];
	int  errors = 0;
	int  send_idle = 0, recv_stall = 0;
	int  hold_cycles = 0;
	int  watch = 0;

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// one step of the regulator
	task automatic predict_loop(sense_req_t r);
		loop_result_t res;
		longint avg, mv, cur, err, inner, total, brk;
		win_sum = win_sum + r.sample - win[WinDepth-1];
		for (int i = WinDepth - 1; i > 0; i--) win[i] = win[i-1];
		win[0] = r.sample;
		avg = win_sum / WinDepth;
		mv = sat((avg * mv_scale) >>> 16, 0, 65535);
		brk = 1300 + 100 * corr_ptr;
		if (duty > brk && corr_ptr < CorrLast) corr_ptr++;
		else if (duty < brk && corr_ptr > 0) corr_ptr--;
		cur = sat(((mv / 25) * 5 * CorrRom[corr_ptr]) >>> 14, 0, 65535);
		res.updated = (tick % WinDepth) == 0;
		tick = tick + 1;
		if (res.updated) begin
			err = sat(longint'(r.target) - cur, -32768, 32767);
			integ = sat(integ + err, -64'sd2147483648, 64'sd2147483647);
			inner = sat(err * 65536 + longint'(ki) * integ, -(64'sd1 <<< 46), 64'sd1 <<< 46);
			total = longint'(duty) * 16777216 + inner * longint'(kp);
			duty = total < 0 ? 16'd0 : 16'(sat(total >>> 24, 0, 65535));
		end
		res.duty = duty;
		res.current = 16'(cur);
		expected_results.push_back(res);
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// driver
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			predict_loop(sense_req_t'(s_axis_tdata[26:0]));
			void'(pending_reqs.pop_front());
		end
		if ((s_axis_tvalid && s_axis_tready) || !s_axis_tvalid) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
				s_axis_tvalid <= 1;
				s_axis_tdata <= {5'd0, pending_reqs[0]};
			end else
				s_axis_tvalid <= 0;
		end
	end

	// long receiver hold-off, counted down here
	always @(posedge clk) begin
		if (hold_cycles > 0)
			hold_cycles <= hold_cycles - 1;
	end

	// monitor
	always @(posedge clk) begin
		loop_result_t e;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0)
				report_mismatch("unexpected result", m_axis_tdata, 0);
			else begin
				e = expected_results.pop_front();
				if (m_axis_tdata[15:0] !== e.duty)
					report_mismatch("duty_level", m_axis_tdata[15:0], e.duty);
				if (m_axis_tdata[31:16] !== e.current)
					report_mismatch("measured_current_ma", m_axis_tdata[31:16], e.current);
				if (m_axis_tuser !== e.updated)
					report_mismatch("loop_updated", m_axis_tuser, e.updated);
			end
		end
		m_axis_tready <= (hold_cycles == 0) && $urandom_range(99) >= recv_stall;
	end

	// watchdog on accepted requests and results
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			watch <= 0;
		else if (arst_n)
			watch <= watch + 1;
		if (watch >= WatchLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [16:0] val);
		@(posedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_MV_SCALE) mv_scale = val;
		else if (idx == REG_PROP) kp = val[15:0];
		else if (idx == REG_INTEG) ki = val[15:0];
	endtask

	task automatic drain();
		wait (pending_reqs.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
		repeat (250) @(posedge clk);
	endtask

	function automatic sense_req_t rand_req();
		sense_req_t r;
		r.sample = $urandom_range(4095);
		r.target = $urandom_range(3) == 0 ? 15'($urandom) : 15'($urandom_range(2500));
		return r;
	endfunction

	task automatic run_random(int n);
		repeat (n) pending_reqs.push_back(rand_req());
		drain();
	endtask

	initial begin
		for (int i = 0; i < WinDepth; i++) win[i] = '0;
		win_sum = 0; tick = 1; corr_ptr = 0; duty = PulseReset; integ = 0;
		mv_scale = 17'd52816; kp = 16'd768; ki = 16'd1311;
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// directed: field extremes, full-scale window, saturating duty both ways
		pending_reqs.push_back('{target: 15'h7FFF, sample: 12'hFFF});
		pending_reqs.push_back('{target: 15'h0, sample: 12'h0});
		repeat (16) pending_reqs.push_back('{target: 15'h7FFF, sample: 12'hFFF});
		repeat (4) pending_reqs.push_back('{target: 15'h0, sample: 12'hFFF});
		drain();
		write_reg(2'd3, 17'h1FFFF);    // unknown index, ignored
		write_reg(REG_MV_SCALE, 17'h1FFFF);
		write_reg(REG_PROP, 17'hFFFF);
		write_reg(REG_INTEG, 17'hFFFF);
		repeat (40) pending_reqs.push_back('{target: 15'h0, sample: 12'hFFF});
		drain();

		// random phases with differing settings and idling
		write_reg(REG_PROP, 17'd768); write_reg(REG_INTEG, 17'd1311);
		write_reg(REG_MV_SCALE, 17'd52816);
		run_random(250);
		send_idle = 86;
		write_reg(REG_PROP, 17'd0); write_reg(REG_INTEG, 17'd0);
		write_reg(REG_MV_SCALE, 17'd0);
		run_random(100);
		send_idle = 0; recv_stall = 86;
		write_reg(REG_PROP, 17'd200); write_reg(REG_INTEG, 17'd40);
		write_reg(REG_MV_SCALE, 17'd70000);
		run_random(150);
		send_idle = 18; recv_stall = 18;
		write_reg(REG_PROP, 17'($urandom)); write_reg(REG_INTEG, 17'($urandom_range(3000)));
		run_random(200);

		// long output hold-off while requests keep coming
		send_idle = 0; recv_stall = 0;
		hold_cycles = 2000;
		repeat (30) pending_reqs.push_back(rand_req());
		wait (hold_cycles == 0);
		drain();
		write_reg(REG_PROP, 17'd768); write_reg(REG_INTEG, 17'd1311);
		run_random(150);

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
